### rtl/core/rbst_pkg.sv
// Shared types for the ray/box slab test: coordinates, distances, payloads, stage enables.
package rbst_pkg;

	// Axis count of the test
	localparam int unsigned NUM_AXES = 3;

	// Signed fixed-point coordinate, as carried on the ports
	typedef logic signed [31:0] coord_t;

	// Corner minus origin, one bit wider than a coordinate
	typedef logic signed [32:0] diff_t;

	// Full product of a difference and an inverse
	typedef logic signed [64:0] prod_t;

	// Slab distance; the product always fits in 64 signed bits
	typedef logic signed [63:0] dist_t;

	// One ray and one box
	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t inv_dir_x;
		coord_t inv_dir_y;
		coord_t inv_dir_z;
		coord_t box_lo_x;
		coord_t box_lo_y;
		coord_t box_lo_z;
		coord_t box_hi_x;
		coord_t box_hi_y;
		coord_t box_hi_z;
	} ray_box_t;

	// Test outcome
	typedef struct packed {
		logic hit;
	} result_t;

	// Load enables for the stages kept inside a slab lane
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} lane_en_t;

endpackage

### rtl/core/rbst_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface rbst_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rbst_slab.sv
// One axis lane: slab differences, products and ordered near/far distances over three stages.
module rbst_slab (
	input  logic                clk,
	input  rbst_pkg::lane_en_t  en,
	input  rbst_pkg::coord_t    org,
	input  rbst_pkg::coord_t    inv,
	input  rbst_pkg::coord_t    lo,
	input  rbst_pkg::coord_t    hi,
	output rbst_pkg::dist_t     t_near,
	output rbst_pkg::dist_t     t_far
);

	rbst_pkg::diff_t  diff_lo_s1;
	rbst_pkg::diff_t  diff_hi_s1;
	rbst_pkg::coord_t inv_s1;
	rbst_pkg::dist_t  t_lo_s2;
	rbst_pkg::dist_t  t_hi_s2;
	rbst_pkg::dist_t  tn_s3;
	rbst_pkg::dist_t  tf_s3;
	rbst_pkg::prod_t  prod_lo;
	rbst_pkg::prod_t  prod_hi;

	// Stage 1: corner minus origin, widened by one bit
	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_lo_s1 <= $signed({lo[31], lo}) - $signed({org[31], org});
			diff_hi_s1 <= $signed({hi[31], hi}) - $signed({org[31], org});
			inv_s1     <= inv;
		end
	end

	// Stage 2: exact products; top bit is only sign extension
	assign prod_lo = diff_lo_s1 * inv_s1;
	assign prod_hi = diff_hi_s1 * inv_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t_lo_s2 <= $signed(prod_lo[63:0]);
			t_hi_s2 <= $signed(prod_hi[63:0]);
		end
	end

	// Stage 3: order the pair
	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (t_lo_s2 < t_hi_s2) begin
				tn_s3 <= t_lo_s2;
				tf_s3 <= t_hi_s2;
			end else begin
				tn_s3 <= t_hi_s2;
				tf_s3 <= t_lo_s2;
			end
		end
	end

	assign t_near = tn_s3;
	assign t_far  = tf_s3;

endmodule

### rtl/core/ray_box_slab_test.sv
// Ray against axis-aligned box, slab method, five pipeline stages with per-stage flow control.
// Each pair is registered in stages 1 to 5 in turn before its result is offered.
// Throughput: one pair per cycle while rsp.ready is high; bubbles fill during an output stall.
// The multiply stage (a 33 by 32 bit product per slab) sets the clock period.
// Reset (arst_n low) empties every stage; payload registers are not reset.
module ray_box_slab_test (
	input  logic        clk,
	input  logic        arst_n,
	rbst_chan_if.sink   req,
	rbst_chan_if.source rsp
);

	localparam int unsigned NA = rbst_pkg::NUM_AXES;

	rbst_pkg::ray_box_t item;
	rbst_pkg::coord_t   org    [NA];
	rbst_pkg::coord_t   inv    [NA];
	rbst_pkg::coord_t   lo     [NA];
	rbst_pkg::coord_t   hi     [NA];
	rbst_pkg::dist_t    t_near [NA];
	rbst_pkg::dist_t    t_far  [NA];

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               rdy1, rdy2, rdy3, rdy4, rdy5;
	rbst_pkg::lane_en_t lane_en;
	rbst_pkg::dist_t    entry_s4;
	rbst_pkg::dist_t    exit_s4;
	rbst_pkg::dist_t    entry_d;
	rbst_pkg::dist_t    exit_d;
	rbst_pkg::result_t  res_s5;

	// Fan the item out into per-axis lanes
	assign item   = req.data;
	assign org[0] = item.origin_x;
	assign org[1] = item.origin_y;
	assign org[2] = item.origin_z;
	assign inv[0] = item.inv_dir_x;
	assign inv[1] = item.inv_dir_y;
	assign inv[2] = item.inv_dir_z;
	assign lo[0]  = item.box_lo_x;
	assign lo[1]  = item.box_lo_y;
	assign lo[2]  = item.box_lo_z;
	assign hi[0]  = item.box_hi_x;
	assign hi[1]  = item.box_hi_y;
	assign hi[2]  = item.box_hi_z;

	// Flow control: a stage loads when empty or when the next one moves
	assign rdy5 = !v_s5 || rsp.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req.ready = rdy1;

	assign lane_en.s1 = rdy1;
	assign lane_en.s2 = rdy2;
	assign lane_en.s3 = rdy3;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stages 1 to 3 per axis
	for (genvar a = 0; a < NA; a++) begin : g_lane
		rbst_slab u_slab (
			.clk    (clk),
			.en     (lane_en),
			.org    (org[a]),
			.inv    (inv[a]),
			.lo     (lo[a]),
			.hi     (hi[a]),
			.t_near (t_near[a]),
			.t_far  (t_far[a])
		);
	end

	// Stage 4: largest entry and smallest exit over the axes
	always_comb begin
		entry_d = t_near[0];
		exit_d  = t_far[0];
		for (int unsigned a = 1; a < NA; a++) begin
			if (t_near[a] > entry_d) entry_d = t_near[a];
			if (t_far[a] < exit_d)   exit_d  = t_far[a];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			entry_s4 <= entry_d;
			exit_s4  <= exit_d;
		end
	end

	// Stage 5: exit >= max(0, entry), split into two compares
	always_ff @(posedge clk) begin
		if (rdy5) begin
			res_s5.hit <= (exit_s4 >= entry_s4) && !exit_s4[63];
		end
	end

	assign rsp.valid = v_s5;
	assign rsp.data  = res_s5;

endmodule

### dv/rbst_hit_checker.sv
// Checker for the ray/box slab test: predicts the hit flag of each pair and compares results.
module rbst_hit_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  rbst_pkg::ray_box_t  req_data,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  rbst_pkg::result_t   rsp_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rbst_pkg::*;

	logic expected_hits[$];
	int   fail_count = 0;
	int   outstanding = 0;

	assign errors  = fail_count;
	assign pending = outstanding;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Slab test: exact products, entry is the latest near distance, exit the earliest far one
	function automatic logic slab_hit(input ray_box_t rb);
		coord_t org[3];
		coord_t inv[3];
		coord_t lo[3];
		coord_t hi[3];
		diff_t  d_lo, d_hi;
		prod_t  t_lo, t_hi, t_near, t_far, t_entry, t_exit, t_floor;
		org = '{rb.origin_x, rb.origin_y, rb.origin_z};
		inv = '{rb.inv_dir_x, rb.inv_dir_y, rb.inv_dir_z};
		lo  = '{rb.box_lo_x, rb.box_lo_y, rb.box_lo_z};
		hi  = '{rb.box_hi_x, rb.box_hi_y, rb.box_hi_z};
		t_entry = '0;
		t_exit  = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			d_lo = diff_t'(lo[a]) - diff_t'(org[a]);
			d_hi = diff_t'(hi[a]) - diff_t'(org[a]);
			t_lo = prod_t'(d_lo) * prod_t'(inv[a]);
			t_hi = prod_t'(d_hi) * prod_t'(inv[a]);
			t_near = (t_lo < t_hi) ? t_lo : t_hi;
			t_far  = (t_lo < t_hi) ? t_hi : t_lo;
			if (a == 0) begin
				t_entry = t_near;
				t_exit  = t_far;
			end else begin
				if (t_near > t_entry) t_entry = t_near;
				if (t_far < t_exit) t_exit = t_far;
			end
		end
		// only distances ahead of the origin count
		t_floor = (t_entry > 0) ? t_entry : prod_t'(0);
		return (t_exit >= t_floor);
	endfunction

	// Queue a prediction on every input transfer, compare on every output transfer
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			expected_hits.delete();
		end else begin
			if (req_valid && req_ready)
				expected_hits.push_back(slab_hit(req_data));
			if (rsp_valid && rsp_ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("result transfer with no prediction outstanding");
				end else begin
					want = expected_hits.pop_front();
					if (rsp_data.hit !== want)
						report_mismatch($sformatf("hit mismatch: got %b, predicted %b",
							rsp_data.hit, want));
				end
			end
		end
		outstanding = expected_hits.size();
	end

endmodule

### dv/tb_ray_box_slab_test.sv
// Testbench top for the ray/box slab test: clock, reset, stimulus, idling and verdict.
module tb_ray_box_slab_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rbst_pkg::*;

	localparam coord_t ONE   = 32'sh0001_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam int     SPAN  = 200 << 16;
	localparam int     NUM_RANDOM = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   no_idle = 1'b0;
	int   errors;
	int   pending;

	rbst_chan_if #(.payload_t(ray_box_t)) req_ch ();
	rbst_chan_if #(.payload_t(result_t))  rsp_ch ();

	ray_box_slab_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rbst_hit_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_data  (req_ch.data),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_data  (rsp_ch.data),
		.errors    (errors),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	function automatic int idle_cycles();
		return no_idle ? 0 : int'($urandom_range(0, 7));
	endfunction

	function automatic ray_box_t pack_axes(input coord_t o[3], input coord_t i[3],
			input coord_t l[3], input coord_t h[3]);
		ray_box_t p;
		p.origin_x  = o[0]; p.origin_y  = o[1]; p.origin_z  = o[2];
		p.inv_dir_x = i[0]; p.inv_dir_y = i[1]; p.inv_dir_z = i[2];
		p.box_lo_x  = l[0]; p.box_lo_y  = l[1]; p.box_lo_z  = l[2];
		p.box_hi_x  = h[0]; p.box_hi_y  = h[1]; p.box_hi_z  = h[2];
		return p;
	endfunction

	function automatic ray_box_t same_on_all(input coord_t o, input coord_t i,
			input coord_t l, input coord_t h);
		return pack_axes('{o, o, o}, '{i, i, i}, '{l, l, l}, '{h, h, h});
	endfunction

	// Q16.16 reciprocal of a direction; zero direction saturates either way
	function automatic coord_t reciprocal(input longint d);
		longint q;
		if (d == 0)
			return $urandom_range(0, 1) ? C_MAX : C_MIN;
		q = (longint'(1) <<< 32) / d;
		if (q > longint'(C_MAX)) q = longint'(C_MAX);
		if (q < longint'(C_MIN)) q = longint'(C_MIN);
		return coord_t'(q);
	endfunction

	function automatic coord_t near_coord();
		return coord_t'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
	endfunction

	function automatic coord_t corner_value();
		case ($urandom_range(0, 5))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return -1;
			4: return ONE;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Ray and box in a modest range; aimed rays point roughly at the box centre
	function automatic ray_box_t scene_pair(input bit aimed);
		coord_t o[3], i[3], l[3], h[3];
		coord_t c, half, tmp;
		longint dir;
		for (int a = 0; a < 3; a++) begin
			c    = near_coord();
			half = coord_t'($urandom_range(1, 50 << 16));
			l[a] = c - half;
			h[a] = c + half;
			if ($urandom_range(0, 15) == 0) begin
				tmp = l[a]; l[a] = h[a]; h[a] = tmp;
			end
			o[a] = near_coord();
			if (aimed)
				dir = longint'(c) - longint'(o[a])
					+ longint'(int'($urandom_range(0, 2 * half)) - int'(half));
			else
				dir = longint'(near_coord());
			if ($urandom_range(0, 15) == 0) dir = 0;
			i[a] = reciprocal(dir);
		end
		return pack_axes(o, i, l, h);
	endfunction

	function automatic ray_box_t random_pair();
		ray_box_t p;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			p = scene_pair(1'b1);
		end else if (pick < 65) begin
			p = scene_pair(1'b0);
		end else if (pick < 80) begin
			p = pack_axes('{corner_value(), corner_value(), corner_value()},
				'{corner_value(), corner_value(), corner_value()},
				'{corner_value(), corner_value(), corner_value()},
				'{corner_value(), corner_value(), corner_value()});
		end else begin
			// raw noise over every bit
			for (int k = 0; k < 12; k++)
				p[k*32 +: 32] = $urandom;
		end
		return p;
	endfunction

	// One input transfer; valid stays high across back-to-back items
	task automatic send_pair(input ray_box_t p);
		int  gap;
		bit  took;
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= p;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Result side: random stalls before each transfer
	initial begin : result_sink
		int gap;
		bit took;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = idle_cycles();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				took = rsp_ch.valid;
				@(posedge clk);
			end while (!took);
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		ray_box_t p;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes
		send_pair(same_on_all('0, '0, '0, '0));
		send_pair(same_on_all(C_MAX, C_MAX, C_MAX, C_MAX));
		send_pair(same_on_all(C_MIN, C_MIN, C_MIN, C_MIN));
		send_pair(same_on_all(C_MIN, C_MAX, C_MAX, C_MAX));
		send_pair(same_on_all(C_MAX, C_MIN, C_MIN, C_MIN));
		send_pair(same_on_all(C_MIN, C_MIN, C_MAX, C_MIN));
		// plain hit, box behind, origin inside, swapped corners, negative direction
		send_pair(same_on_all('0, ONE, ONE, 2 * ONE));
		send_pair(same_on_all('0, ONE, -2 * ONE, -ONE));
		send_pair(same_on_all('0, ONE, -ONE, ONE));
		send_pair(same_on_all('0, ONE, 2 * ONE, ONE));
		send_pair(same_on_all('0, -ONE, -2 * ONE, -ONE));
		// zero inverse on one axis with the origin outside that slab
		p = same_on_all('0, ONE, ONE, 2 * ONE);
		p.inv_dir_x = '0; p.box_lo_x = 5 * ONE; p.box_hi_x = 6 * ONE;
		send_pair(p);
		// zero inverse everywhere: only distance zero admitted
		send_pair(same_on_all(ONE, '0, 3 * ONE, 4 * ONE));
		// saturated inverse, origin inside then outside the slab
		p = same_on_all('0, ONE, ONE, 2 * ONE);
		p.inv_dir_y = C_MAX; p.box_lo_y = -ONE; p.box_hi_y = ONE;
		send_pair(p);
		p.box_lo_y = ONE; p.box_hi_y = 2 * ONE;
		send_pair(p);
		p.inv_dir_y = C_MIN; p.box_lo_y = -2 * ONE; p.box_hi_y = -ONE;
		send_pair(p);
		// grazing: exit equals entry, then one lsb apart
		p = same_on_all('0, ONE, ONE, 2 * ONE);
		p.box_lo_y = 2 * ONE; p.box_hi_y = 3 * ONE;
		send_pair(p);
		p.box_lo_y = 2 * ONE + 1;
		send_pair(p);
		// exit exactly at the origin, then one lsb behind it
		send_pair(same_on_all('0, ONE, -ONE, '0));
		send_pair(same_on_all('0, ONE, -ONE, -1));

		// random part, idling switched off for some stretches
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 100 == 0)
				no_idle = (n / 100 == 1) || ($urandom_range(0, 3) == 0);
			send_pair(random_pair());
		end
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;

		// drain, then allow the pipeline depth for stray results
		do @(negedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
